// File: hw/rtl/assert_macros.svh
// Assertion helpers used by the RTL controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define MER_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed (same-cycle implication)");

// Next-cycle implication.
`define MER_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed (next-cycle implication)");

`endif

// File: hw/rtl/mer_pkg.sv
package mer_pkg;

   // Default widths
   localparam int COORD_BITS_DEF  = 12;
   localparam int RADIUS_BITS_DEF = 10;

   // Register index codes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_X = CSR_IDX_W'(2);
   localparam logic [CSR_IDX_W-1:0] CSR_RADIUS_Y = CSR_IDX_W'(3);

   // Datapath micro-operations
   typedef enum logic [4:0] {
      OP_NONE,
      OP_RST_MUL,
      OP_RST_ACC,
      OP_SET_D,
      OP_A0,
      OP_A1,
      OP_A2,
      OP_B0,
      OP_B1,
      OP_B2,
      OP_S0,
      OP_S1,
      OP_T0,
      OP_T1,
      OP_T2,
      OP_T3,
      OP_T4,
      OP_T5,
      OP_EMIT
   } mer_op_type;

   typedef struct packed {
      mer_op_type op;
      logic       last;
   } mer_cmd_type;

   typedef struct packed {
      logic y_zero;
      logic y_one;
      logic more;
   } mer_sts_type;

endpackage

// File: hw/rtl/mer_if.sv
interface mer_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink (input valid, input restart, output ready);
endinterface

interface mer_rsp_if #(
   parameter int COORD_BITS = mer_pkg::COORD_BITS_DEF
);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] right_x;
   logic signed [COORD_BITS-1:0] left_x;
   logic signed [COORD_BITS-1:0] top_y;
   logic signed [COORD_BITS-1:0] bottom_y;
   logic                         last;

   modport source (output valid, output right_x, output left_x, output top_y,
                   output bottom_y, output last, input ready);
   modport sink (input valid, input right_x, input left_x, input top_y,
                 input bottom_y, input last, output ready);
endinterface

// File: hw/rtl/midpoint_ellipse_rasterizer_core.sv
// A restart or a region-one step runs its update, the region-one test and, when the
// arc moves on to region two, the region-two setup; a region-two step runs its update
// only (one shared multiplier, one product a cycle, sequenced by the controller).
// A new request is taken in the cycle after its predecessor's result is loaded;
// a request that produces no result frees the port on the next cycle.
// Reset is synchronous: configuration and arc state clear, no arc is in progress.
module midpoint_ellipse_rasterizer_core #(
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   localparam int CSR_W = (COORD_BITS - 1 > RADIUS_BITS) ? COORD_BITS - 1 : RADIUS_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   mer_req_if.sink                       req_ch,
   mer_rsp_if.source                     rsp_ch,
   input  logic                          csr_write,
   input  logic [mer_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]              csr_wdata
);
   import mer_pkg::*;

   mer_cmd_type cmd;
   mer_sts_type sts;
   logic        ctl_req_ready;
   logic        ctl_rsp_valid;

   // Sequence the step
   mer_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_restart (req_ch.restart),
      .req_ready   (ctl_req_ready),
      .rsp_ready   (rsp_ch.ready),
      .rsp_valid   (ctl_rsp_valid),
      .cmd         (cmd),
      .sts         (sts)
   );

   // Compute decision terms and point sets
   mer_dpath #(
      .COORD_BITS  (COORD_BITS),
      .RADIUS_BITS (RADIUS_BITS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .sts          (sts),
      .out_right_x  (rsp_ch.right_x),
      .out_left_x   (rsp_ch.left_x),
      .out_top_y    (rsp_ch.top_y),
      .out_bottom_y (rsp_ch.bottom_y),
      .out_last     (rsp_ch.last)
   );

   assign req_ch.ready = ctl_req_ready;
   assign rsp_ch.valid = ctl_rsp_valid;

endmodule

// File: hw/rtl/mer_dpath.sv
module mer_dpath #(
   parameter int COORD_BITS  = mer_pkg::COORD_BITS_DEF,
   parameter int RADIUS_BITS = mer_pkg::RADIUS_BITS_DEF,
   localparam int CSR_W = (COORD_BITS - 1 > RADIUS_BITS) ? COORD_BITS - 1 : RADIUS_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [mer_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_W-1:0]                csr_wdata,
   input  mer_pkg::mer_cmd_type            cmd,
   output mer_pkg::mer_sts_type            sts,
   output logic signed [COORD_BITS-1:0]    out_right_x,
   output logic signed [COORD_BITS-1:0]    out_left_x,
   output logic signed [COORD_BITS-1:0]    out_top_y,
   output logic signed [COORD_BITS-1:0]    out_bottom_y,
   output logic                            out_last
);
   import mer_pkg::*;

   localparam int CW  = COORD_BITS - 1;
   localparam int XW  = RADIUS_BITS + 1;
   localparam int SQW = 2 * RADIUS_BITS;
   localparam int MAW = SQW + 1;
   localparam int MBW = SQW + 5;
   localparam int PW  = MAW + MBW;
   localparam int PW1 = PW + 1;
   localparam int DW  = 4 * RADIUS_BITS + 8;

   // Configuration and squared radii
   logic signed [CW-1:0]          cx_ff, cy_ff;
   logic [RADIUS_BITS-1:0]        ry_ff;
   logic [SQW-1:0]                sa_ff, sb_ff;
   logic [RADIUS_BITS-1:0]        csr_rad;
   logic [SQW-1:0]                csr_sq;

   // Arc state and work registers
   logic [XW-1:0]                 x_ff, x_in, y_ff, y_in;
   logic signed [DW-1:0]          d_ff, d_in, acc_ff, acc_in;
   logic signed [PW-1:0]          p_ff, p_in, t_ff, t_in;

   // Operand terms
   logic signed [MBW-1:0]         xe, ye, rye, sbe, xodd_w, ym1_w;
   logic signed [MAW-1:0]         mul_a;
   logic signed [MBW-1:0]         mul_b;
   logic signed [DW-1:0]          pe, sae_d, sbe_d, acc_round, d_trunc;
   logic signed [PW1-1:0]         t_w, p2_w;
   logic                          d_neg;
   logic signed [COORD_BITS-1:0]  rx_sum, lx_sum, ty_sum, by_sum;

   // Square the radius on its way in
   assign csr_rad = csr_wdata[RADIUS_BITS-1:0];
   assign csr_sq  = SQW'(csr_rad) * SQW'(csr_rad);

   // Take configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cx_ff <= '0;
         cy_ff <= '0;
         ry_ff <= '0;
         sa_ff <= '0;
         sb_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_CENTER_X: cx_ff <= csr_wdata[CW-1:0];
            CSR_CENTER_Y: cy_ff <= csr_wdata[CW-1:0];
            CSR_RADIUS_X: sa_ff <= csr_sq;
            CSR_RADIUS_Y: begin
               ry_ff <= csr_rad;
               sb_ff <= csr_sq;
            end
            default: ;
         endcase
      end
   end

   // Widen the coordinates for operand building
   assign xe     = signed'(MBW'(x_ff));
   assign ye     = signed'(MBW'(y_ff));
   assign rye    = signed'(MBW'(ry_ff));
   assign sbe    = signed'(MBW'(sb_ff));
   assign xodd_w = xe + xe + MBW'(1);
   assign ym1_w  = ye - MBW'(1);

   assign pe        = DW'(p_ff);
   assign sae_d     = signed'(DW'(sa_ff));
   assign sbe_d     = signed'(DW'(sb_ff));
   assign d_neg     = d_ff[DW-1];
   assign acc_round = acc_ff + (acc_ff[DW-1] ? DW'(3) : DW'(0));
   assign d_trunc   = acc_round >>> 2;

   // Shared multiplier, one product a cycle
   assign p_in = mul_a * mul_b;

   // Select operands and next state per micro-operation
   always_comb begin
      mul_a  = signed'(MAW'(sa_ff));
      mul_b  = '0;
      x_in   = x_ff;
      y_in   = y_ff;
      d_in   = d_ff;
      acc_in = acc_ff;
      t_in   = t_ff;
      unique case (cmd.op)
         OP_RST_MUL: begin
            x_in  = '0;
            y_in  = XW'(ry_ff);
            mul_b = rye;
         end
         OP_RST_ACC: acc_in = (sbe_d <<< 2) + sae_d - (pe <<< 2);
         OP_SET_D:   d_in = d_trunc;
         OP_A0: begin
            mul_a = signed'(MAW'(sb_ff));
            mul_b = xe + xe + MBW'(3);
         end
         OP_A1: begin
            acc_in = d_ff + pe;
            mul_b  = ye + ye - MBW'(2);
         end
         OP_A2: begin
            x_in = x_ff + XW'(1);
            if (d_neg) begin
               d_in = acc_ff;
            end else begin
               d_in = acc_ff - pe;
               y_in = y_ff - XW'(1);
            end
         end
         OP_B0: mul_b = MBW'(3) - ye - ye;
         OP_B1: begin
            acc_in = d_ff + pe;
            mul_a  = signed'(MAW'(sb_ff));
            mul_b  = xe + xe + MBW'(2);
         end
         OP_B2: begin
            y_in = y_ff - XW'(1);
            if (d_neg) begin
               d_in = acc_ff + pe;
               x_in = x_ff + XW'(1);
            end else begin
               d_in = acc_ff;
            end
         end
         OP_S0: mul_b = ye + ye - MBW'(1);
         OP_S1: begin
            t_in  = p_ff;
            mul_a = signed'(MAW'(sb_ff));
            mul_b = xe + MBW'(1);
         end
         OP_T0: begin
            mul_a = signed'(xodd_w[MAW-1:0]);
            mul_b = xodd_w;
         end
         OP_T1: begin
            t_in  = p_ff;
            mul_a = signed'(ym1_w[MAW-1:0]);
            mul_b = ym1_w;
         end
         OP_T2: mul_b = signed'(p_ff[MBW-1:0]);
         OP_T3: begin
            acc_in = pe <<< 2;
            mul_a  = signed'(MAW'(sb_ff));
            mul_b  = signed'(t_ff[MBW-1:0]);
         end
         OP_T4: begin
            acc_in = acc_ff + pe;
            mul_b  = sbe;
         end
         OP_T5:   acc_in = acc_ff - (pe <<< 2);
         OP_NONE: ;
         OP_EMIT: ;
         default: ;
      endcase
   end

   // Hold arc state
   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         d_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         d_ff <= d_in;
      end
   end

   // Advance work registers
   always_ff @(posedge clock) begin
      p_ff   <= p_in;
      t_ff   <= t_in;
      acc_ff <= acc_in;
   end

   // Region one test: sa*(2y-1) > 2*sb*(x+1)
   assign t_w  = PW1'(t_ff);
   assign p2_w = PW1'(p_ff) <<< 1;

   assign sts.more   = (t_w > p2_w);
   assign sts.y_zero = (y_ff == '0);
   assign sts.y_one  = (y_ff == XW'(1));

   // Mirror the offsets around the center
   assign rx_sum = COORD_BITS'(cx_ff) + COORD_BITS'(x_ff);
   assign lx_sum = COORD_BITS'(cx_ff) - COORD_BITS'(x_ff);
   assign ty_sum = COORD_BITS'(cy_ff) + COORD_BITS'(y_ff);
   assign by_sum = COORD_BITS'(cy_ff) - COORD_BITS'(y_ff);

   // Load the result register
   always_ff @(posedge clock) begin
      if (cmd.op == OP_EMIT) begin
         out_right_x  <= rx_sum;
         out_left_x   <= lx_sum;
         out_top_y    <= ty_sum;
         out_bottom_y <= by_sum;
         out_last     <= cmd.last;
      end
   end

endmodule

// File: hw/rtl/mer_ctrl.sv
`include "assert_macros.svh"

module mer_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_restart,
   output logic                 req_ready,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output mer_pkg::mer_cmd_type cmd,
   input  mer_pkg::mer_sts_type sts
);
   import mer_pkg::*;

   typedef enum logic [20:0] {
      ST_WAIT = 21'h000001,
      ST_R0   = 21'h000002,
      ST_R1   = 21'h000004,
      ST_R2   = 21'h000008,
      ST_A0   = 21'h000010,
      ST_A1   = 21'h000020,
      ST_A2   = 21'h000040,
      ST_B0   = 21'h000080,
      ST_B1   = 21'h000100,
      ST_B2   = 21'h000200,
      ST_S0   = 21'h000400,
      ST_S1   = 21'h000800,
      ST_S2   = 21'h001000,
      ST_T0   = 21'h002000,
      ST_T1   = 21'h004000,
      ST_T2   = 21'h008000,
      ST_T3   = 21'h010000,
      ST_T4   = 21'h020000,
      ST_T5   = 21'h040000,
      ST_T6   = 21'h080000,
      ST_EMIT = 21'h100000
   } mer_state_type;

   typedef enum logic [3:0] {
      PH_IDLE = 4'b0001,
      PH_ONE  = 4'b0010,
      PH_TWO  = 4'b0100,
      PH_DONE = 4'b1000
   } mer_phase_type;

   mer_state_type state_ff, state_in;
   mer_phase_type phase_ff, phase_in;
   logic          last_ff, last_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          accept;
   logic          drop_req;
   logic          emit_stall;
   logic          emit_last;

   assign req_ready = (state_ff == ST_WAIT);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && req_ready;

   // Flag the cases the assertions watch
   assign drop_req   = accept && !req_restart && (phase_ff == PH_IDLE || phase_ff == PH_DONE);
   assign emit_stall = (state_ff == ST_EMIT) && rsp_valid_ff && !rsp_ready;
   assign emit_last  = (cmd.op == OP_EMIT) && last_ff;

   // Sequence micro-operations
   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      last_in      = last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd.op       = OP_NONE;
      cmd.last     = last_ff;
      unique case (state_ff)
         ST_WAIT: begin
            if (accept) begin
               priority if (req_restart) state_in = ST_R0;
               else if (phase_ff == PH_ONE) state_in = ST_A0;
               else if (phase_ff == PH_TWO) state_in = ST_B0;
               else state_in = ST_WAIT;
            end
         end
         ST_R0: begin
            cmd.op   = OP_RST_MUL;
            state_in = ST_R1;
         end
         ST_R1: begin
            cmd.op   = OP_RST_ACC;
            state_in = ST_R2;
         end
         ST_R2: begin
            cmd.op   = OP_SET_D;
            phase_in = PH_ONE;
            state_in = ST_S0;
         end
         ST_A0: begin
            cmd.op   = OP_A0;
            state_in = ST_A1;
         end
         ST_A1: begin
            cmd.op   = OP_A1;
            state_in = ST_A2;
         end
         ST_A2: begin
            cmd.op   = OP_A2;
            state_in = ST_S0;
         end
         ST_B0: begin
            cmd.op   = OP_B0;
            state_in = ST_B1;
         end
         ST_B1: begin
            cmd.op   = OP_B1;
            state_in = ST_B2;
         end
         ST_B2: begin
            // the arc ends when y steps down to zero
            cmd.op   = OP_B2;
            last_in  = sts.y_one;
            phase_in = sts.y_one ? PH_DONE : PH_TWO;
            state_in = ST_EMIT;
         end
         ST_S0: begin
            cmd.op   = OP_S0;
            state_in = ST_S1;
         end
         ST_S1: begin
            cmd.op   = OP_S1;
            state_in = ST_S2;
         end
         ST_S2: begin
            // stay in region one, end the arc, or set up region two
            priority if (sts.more) begin
               last_in  = 1'b0;
               state_in = ST_EMIT;
            end else if (sts.y_zero) begin
               last_in  = 1'b1;
               phase_in = PH_DONE;
               state_in = ST_EMIT;
            end else begin
               state_in = ST_T0;
            end
         end
         ST_T0: begin
            cmd.op   = OP_T0;
            state_in = ST_T1;
         end
         ST_T1: begin
            cmd.op   = OP_T1;
            state_in = ST_T2;
         end
         ST_T2: begin
            cmd.op   = OP_T2;
            state_in = ST_T3;
         end
         ST_T3: begin
            cmd.op   = OP_T3;
            state_in = ST_T4;
         end
         ST_T4: begin
            cmd.op   = OP_T4;
            state_in = ST_T5;
         end
         ST_T5: begin
            cmd.op   = OP_T5;
            state_in = ST_T6;
         end
         ST_T6: begin
            cmd.op   = OP_SET_D;
            last_in  = 1'b0;
            phase_in = PH_TWO;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            // wait for the result register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = OP_EMIT;
               rsp_valid_in = 1'b1;
               state_in     = ST_WAIT;
            end
         end
         default: state_in = ST_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WAIT;
         phase_ff     <= PH_IDLE;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `MER_ASSERT_NEXT(a_restart_starts, clock, reset, accept && req_restart, state_ff == ST_R0)
   `MER_ASSERT_NEXT(a_drop_when_idle, clock, reset, drop_req, state_ff == ST_WAIT)
   `MER_ASSERT_NEXT(a_emit_holds, clock, reset, emit_stall, state_ff == ST_EMIT)
   `MER_ASSERT_NEXT(a_last_ends_arc, clock, reset, emit_last, phase_ff == PH_DONE)

endmodule

// File: sim/tb_top.sv
module tb_top;

   localparam int COORD_BITS   = mer_pkg::COORD_BITS_DEF;
   localparam int RADIUS_BITS  = mer_pkg::RADIUS_BITS_DEF;
   localparam int CSR_W        = (COORD_BITS - 1 > RADIUS_BITS) ? COORD_BITS - 1 : RADIUS_BITS;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES   = 400;
   localparam int RANDOM_POINTS = 1000;
   localparam int MAX_REPORTS   = 10;

   typedef enum logic [1:0] {ARC_IDLE, ARC_ONE, ARC_TWO, ARC_DONE} arc_state_type;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] right_x;
      logic signed [COORD_BITS-1:0] left_x;
      logic signed [COORD_BITS-1:0] top_y;
      logic signed [COORD_BITS-1:0] bottom_y;
      logic                         last;
   } ellipse_point_type;

   // Track the arc and queue the point sets it must emit
   class arc_scoreboard;
      logic signed [COORD_BITS-2:0] ctr_x;
      logic signed [COORD_BITS-2:0] ctr_y;
      logic [RADIUS_BITS-1:0]       rad_x;
      logic [RADIUS_BITS-1:0]       rad_y;
      longint                       off_x;
      longint                       off_y;
      longint                       decision;
      arc_state_type                state;
      ellipse_point_type            due[$];
      int                           failures;

      function new();
         ctr_x = '0;
         ctr_y = '0;
         rad_x = '0;
         rad_y = '0;
         off_x = 0;
         off_y = 0;
         decision = 0;
         state = ARC_IDLE;
         failures = 0;
      endfunction

      function void set_reg(logic [mer_pkg::CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
         case (idx)
            mer_pkg::CSR_CENTER_X: ctr_x = val[COORD_BITS-2:0];
            mer_pkg::CSR_CENTER_Y: ctr_y = val[COORD_BITS-2:0];
            mer_pkg::CSR_RADIUS_X: rad_x = val[RADIUS_BITS-1:0];
            default:               rad_y = val[RADIUS_BITS-1:0];
         endcase
      endfunction

      function bit arc_live();
         return (state == ARC_ONE) || (state == ARC_TWO);
      endfunction

      function int pending();
         return due.size();
      endfunction

      // Apply one request; return 1 when it yields a point set
      function bit note(bit restart);
         longint            sa;
         longint            sb;
         longint            t;
         ellipse_point_type p;
         sa = longint'(rad_x) * longint'(rad_x);
         sb = longint'(rad_y) * longint'(rad_y);
         if (restart) begin
            off_x = 0;
            off_y = longint'(rad_y);
            decision = (4 * sb - 4 * sa * off_y + sa) / 4;
            state = ARC_ONE;
         end else if (state == ARC_ONE) begin
            if (decision < 0) begin
               decision += sb * (2 * off_x + 3);
            end else begin
               decision += sb * (2 * off_x + 3) + sa * (2 - 2 * off_y);
               off_y--;
            end
            off_x++;
         end else if (state == ARC_TWO) begin
            if (decision < 0) begin
               decision += sb * (2 * off_x + 2) + sa * (3 - 2 * off_y);
               off_x++;
            end else begin
               decision += sa * (3 - 2 * off_y);
            end
            off_y--;
         end else begin
            return 1'b0;
         end

         // Decide region change or end of arc
         p.last = 1'b0;
         if (state == ARC_ONE) begin
            if (sa * (2 * off_y - 1) <= 2 * sb * (off_x + 1)) begin
               if (off_y > 0) begin
                  t = sb * (2 * off_x + 1) * (2 * off_x + 1)
                      + 4 * sa * (off_y - 1) * (off_y - 1) - 4 * sa * sb;
                  decision = t / 4;
                  state = ARC_TWO;
               end else begin
                  state = ARC_DONE;
                  p.last = 1'b1;
               end
            end
         end else if (off_y <= 0) begin
            state = ARC_DONE;
            p.last = 1'b1;
         end

         p.right_x  = COORD_BITS'(longint'(ctr_x) + off_x);
         p.left_x   = COORD_BITS'(longint'(ctr_x) - off_x);
         p.top_y    = COORD_BITS'(longint'(ctr_y) + off_y);
         p.bottom_y = COORD_BITS'(longint'(ctr_y) - off_y);
         due.push_back(p);
         return 1'b1;
      endfunction

      // Compare a point set against the oldest one due
      function void check(ellipse_point_type got);
         ellipse_point_type want;
         if (due.size() == 0) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display("unexpected point set: rx=%0d lx=%0d ty=%0d by=%0d last=%0b",
                        got.right_x, got.left_x, got.top_y, got.bottom_y, got.last);
            return;
         end
         want = due.pop_front();
         if (got.right_x !== want.right_x || got.left_x !== want.left_x ||
             got.top_y !== want.top_y || got.bottom_y !== want.bottom_y ||
             got.last !== want.last) begin
            failures++;
            if (failures <= MAX_REPORTS)
               $display({"mismatch: expected rx=%0d lx=%0d ty=%0d by=%0d last=%0b,",
                         " got rx=%0d lx=%0d ty=%0d by=%0d last=%0b"},
                        want.right_x, want.left_x, want.top_y, want.bottom_y, want.last,
                        got.right_x, got.left_x, got.top_y, got.bottom_y, got.last);
         end
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          csr_write;
   logic [mer_pkg::CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]              csr_wdata;

   mer_req_if                            req_bus ();
   mer_rsp_if #(.COORD_BITS(COORD_BITS)) rsp_bus ();

   arc_scoreboard     board = new();
   ellipse_point_type seen_point;
   int                send_idle_pct = 0;
   int                recv_idle_pct = 0;
   int                hold_asks = 0;
   int                points_sent = 0;

   midpoint_ellipse_rasterizer_core u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Drive response ready: random stalls plus one long hold when a hold is asked for
   initial begin
      int hold_left;
      int holds_seen;
      hold_left = 0;
      holds_seen = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holds_seen != hold_asks) begin
            holds_seen = hold_asks;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Check every accepted point set
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen_point.right_x  = rsp_bus.right_x;
         seen_point.left_x   = rsp_bus.left_x;
         seen_point.top_y    = rsp_bus.top_y;
         seen_point.bottom_y = rsp_bus.bottom_y;
         seen_point.last     = rsp_bus.last;
         board.check(seen_point);
      end
   end

   function automatic logic [CSR_W-1:0] pick_center();
      int sel;
      sel = $urandom_range(99);
      if (sel < 8)
         return CSR_W'(11'h3FF);
      else if (sel < 16)
         return CSR_W'(11'h400);
      return CSR_W'($urandom);
   endfunction

   // Mostly small radii so arcs stay short; a few at the extremes
   function automatic logic [CSR_W-1:0] pick_radius();
      logic [CSR_W-1:0] val;
      int               sel;
      val = CSR_W'($urandom);
      sel = $urandom_range(99);
      if (sel < 70)
         val[RADIUS_BITS-1:0] = RADIUS_BITS'($urandom_range(12));
      else if (sel < 88)
         val[RADIUS_BITS-1:0] = RADIUS_BITS'($urandom_range(80));
      else if (sel < 94)
         val[RADIUS_BITS-1:0] = $urandom_range(1) ? '1 : '0;
      else
         val[RADIUS_BITS-1:0] = RADIUS_BITS'($urandom);
      return val;
   endfunction

   task automatic write_reg(logic [mer_pkg::CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      board.set_reg(idx, val);
      csr_write <= 1'b0;
      @(posedge clock);
   endtask

   // Offer one request with random lead-in gaps; hold until accepted
   task automatic send_item(bit restart);
      while ($urandom_range(99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.restart <= restart;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      if (board.note(restart))
         points_sent++;
   endtask

   // Stop offering, wait for every due point set, then let the core settle
   task automatic drain();
      req_bus.valid <= 1'b0;
      while (board.pending() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Restart an arc and step it to its end or to the step cap
   task automatic run_arc(int max_steps);
      int steps;
      steps = 0;
      send_item(1'b1);
      while (board.arc_live() && steps < max_steps) begin
         if ($urandom_range(99) < 2) begin
            drain();
            if ($urandom_range(1))
               write_reg(mer_pkg::CSR_CENTER_X, pick_center());
            else
               write_reg(mer_pkg::CSR_CENTER_Y, pick_center());
         end
         send_item(1'b0);
         steps++;
      end
      if (!board.arc_live() && $urandom_range(99) < 25)
         send_item(1'b0);
   endtask

   initial begin
      int         stage_start;
      logic [3:0] pick;
      reset           <= 1'b1;
      csr_write       <= 1'b0;
      csr_index       <= mer_pkg::CSR_CENTER_X;
      csr_wdata       <= '0;
      req_bus.valid   <= 1'b0;
      req_bus.restart <= 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: advance with no arc in progress
      send_item(1'b0);
      drain();

      // Directed: zero radii, then advance after the arc has ended
      write_reg(mer_pkg::CSR_CENTER_X, '0);
      write_reg(mer_pkg::CSR_CENTER_Y, '0);
      write_reg(mer_pkg::CSR_RADIUS_X, '0);
      write_reg(mer_pkg::CSR_RADIUS_Y, '0);
      send_item(1'b1);
      send_item(1'b0);
      drain();

      // Directed: zero y radius ends on the restart point
      write_reg(mer_pkg::CSR_RADIUS_X, CSR_W'(3));
      send_item(1'b1);
      drain();

      // Directed: zero x radius goes straight to region two
      write_reg(mer_pkg::CSR_RADIUS_X, '0);
      write_reg(mer_pkg::CSR_RADIUS_Y, CSR_W'(3));
      run_arc(20);
      drain();

      // Directed: full small arc at the center extremes
      write_reg(mer_pkg::CSR_CENTER_X, CSR_W'(11'h400));
      write_reg(mer_pkg::CSR_CENTER_Y, CSR_W'(11'h3FF));
      write_reg(mer_pkg::CSR_RADIUS_X, CSR_W'(4));
      write_reg(mer_pkg::CSR_RADIUS_Y, CSR_W'(3));
      run_arc(20);
      drain();

      // Directed: move the center in the middle of an arc
      write_reg(mer_pkg::CSR_RADIUS_X, CSR_W'(5));
      write_reg(mer_pkg::CSR_RADIUS_Y, CSR_W'(4));
      send_item(1'b1);
      send_item(1'b0);
      send_item(1'b0);
      drain();
      write_reg(mer_pkg::CSR_CENTER_X, CSR_W'(11'h3FF));
      write_reg(mer_pkg::CSR_CENTER_Y, CSR_W'(11'h400));
      while (board.arc_live())
         send_item(1'b0);
      drain();

      // Random: three idling profiles
      for (int stage = 0; stage < 3; stage++) begin
         case (stage)
            0: begin
               send_idle_pct = 6;
               recv_idle_pct = 81;
            end
            1: begin
               send_idle_pct = 81;
               recv_idle_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase

         // Start of the largest arc, with a long response hold while requests keep coming
         if (stage == 0) begin
            write_reg(mer_pkg::CSR_CENTER_X, CSR_W'(11'h3FF));
            write_reg(mer_pkg::CSR_CENTER_Y, CSR_W'(11'h400));
            write_reg(mer_pkg::CSR_RADIUS_X, CSR_W'(10'h3FF));
            write_reg(mer_pkg::CSR_RADIUS_Y, CSR_W'(10'h3FF));
            hold_asks++;
            run_arc(100);
         end

         stage_start = points_sent;
         while (points_sent - stage_start < RANDOM_POINTS / 3) begin
            if ($urandom_range(99) < 30) begin
               drain();
               pick = 4'($urandom_range(15));
               if (pick == 4'd0)
                  pick = 4'hF;
               if (pick[0]) write_reg(mer_pkg::CSR_CENTER_X, pick_center());
               if (pick[1]) write_reg(mer_pkg::CSR_CENTER_Y, pick_center());
               if (pick[2]) write_reg(mer_pkg::CSR_RADIUS_X, pick_radius());
               if (pick[3]) write_reg(mer_pkg::CSR_RADIUS_Y, pick_radius());
            end
            if ($urandom_range(99) < 5)
               send_item(1'b0);
            run_arc(($urandom_range(99) < 10) ? $urandom_range(8) : 200);
         end
      end

      drain();
      if (board.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   // Give up on a hung run
   initial begin
      #24000000;
      $display("status: fail");
      $finish;
   end

endmodule

// File: sim.f
+incdir+hw/rtl
hw/rtl/mer_pkg.sv
hw/rtl/mer_if.sv
hw/rtl/mer_dpath.sv
hw/rtl/mer_ctrl.sv
hw/rtl/midpoint_ellipse_rasterizer_core.sv
sim/tb_top.sv
